>>> src/dbm_pkg.sv
// Shared types and constants for the depth background mask.
`default_nettype none
package dbm_pkg;

  localparam int MaxPixels = 524288;
  localparam int AddrW     = $clog2(MaxPixels);
  localparam int DepthW    = 16;
  localparam int ThreshW   = 17;
  localparam int CfgIdxW   = 2;

  localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODE      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE    = 2'd2;

  localparam logic signed [ThreshW-1:0] THRESHOLD_RESET = 17'sd100;

  localparam logic CMD_PIXEL   = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  localparam logic MODE_NEARER = 1'b0;
  localparam logic MODE_WITHIN = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [AddrW-1:0] pos;
    logic             store;
  } frame_ctrl_t;

endpackage
`default_nettype wire

>>> src/dbm_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module dbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/dbm_frame_ctrl.sv
// Frame tracking: pixel position, capture request and capture frame flags.
`default_nettype none
module dbm_frame_ctrl
  import dbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        pix_acc,
  input  wire logic        cmd_acc,
  input  wire logic        last,
  input  wire logic        enable,
  output      frame_ctrl_t ctrl
);

  logic [AddrW-1:0] pixel_index;
  logic [AddrW-1:0] pixel_index_next;
  logic             capture_pending;
  logic             capture_pending_next;
  logic             capturing;
  logic             capturing_next;
  logic             at_frame_start;
  logic             at_frame_start_next;

  always_comb begin
    capture_pending_next = capture_pending;
    capturing_next       = capturing;
    at_frame_start_next  = at_frame_start;
    pixel_index_next     = pixel_index;
    if (cmd_acc) begin
      capture_pending_next = 1'b1;
    end
    if (pix_acc) begin
      if (at_frame_start) begin
        capturing_next = enable & capture_pending;
        if (enable) begin
          capture_pending_next = 1'b0;
        end
      end
      if (last) begin
        pixel_index_next    = '0;
        at_frame_start_next = 1'b1;
      end else begin
        at_frame_start_next = 1'b0;
        if (pixel_index == AddrW'(MaxPixels - 1)) begin
          pixel_index_next = '0;
        end else begin
          pixel_index_next = pixel_index + AddrW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_index     <= '0;
      capture_pending <= 1'b1;
      capturing       <= 1'b0;
      at_frame_start  <= 1'b1;
    end else begin
      pixel_index     <= pixel_index_next;
      capture_pending <= capture_pending_next;
      capturing       <= capturing_next;
      at_frame_start  <= at_frame_start_next;
    end
  end

  assign ctrl.pos   = pixel_index;
  assign ctrl.store = pix_acc & enable &
                      (at_frame_start ? capture_pending : capturing);

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    (pix_acc && last) |=> (pixel_index == '0 && at_frame_start))
    else $error("position not rewound after frame end");

  a_store_needs_enable: assert property (@(posedge clk) disable iff (rst)
    ctrl.store |-> (enable && pix_acc && !cmd_acc))
    else $error("reference store outside an enabled pixel transaction");

  a_cmd_sets_pending: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |=> capture_pending)
    else $error("capture request lost");

endmodule
`default_nettype wire

>>> src/dbm_classify.sv
// Compare stage against the reference depth and result register.
`default_nettype none
module dbm_classify
  import dbm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire pixel_t                    pix_in,
  input  wire logic                      store_in,
  input  wire logic [DepthW-1:0]         ref_rdata,
  input  wire logic signed [ThreshW-1:0] threshold,
  input  wire logic                      compare_mode,
  input  wire logic                      enable,
  output      logic                      ready,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      pixel_t                    out_pix
);

  logic   s1_valid;
  pixel_t s1_pix;
  logic   s1_store;
  logic   out_free;
  logic   adv;

  logic [DepthW-1:0]           depth;
  logic [DepthW-1:0]           ref_depth;
  logic signed [DepthW+2:0]    ref_minus_thr;
  logic signed [DepthW+1:0]    diff;
  logic [ThreshW-1:0]          abs_diff;
  logic [ThreshW-1:0]          abs_thr;
  logic                        bg;
  pixel_t                      res;

  assign out_free = ~out_valid | out_ready;
  assign adv      = s1_valid & out_free;
  assign ready    = ~s1_valid | out_free;

  always_comb begin
    depth         = {s1_pix.red, s1_pix.green};
    ref_depth     = s1_store ? depth : ref_rdata;
    ref_minus_thr = $signed({3'b000, ref_depth}) -
                    $signed({{2{threshold[ThreshW-1]}}, threshold});
    diff          = $signed({2'b00, depth}) - $signed({2'b00, ref_depth});
    abs_diff      = diff[DepthW+1] ? ThreshW'(-diff) : ThreshW'(diff);
    abs_thr       = threshold[ThreshW-1] ? ThreshW'(-threshold) : ThreshW'(threshold);
    if (compare_mode == MODE_WITHIN) begin
      bg = abs_diff < abs_thr;
    end else begin
      bg = $signed({3'b000, depth}) > ref_minus_thr;
    end
    res = s1_pix;
    if (enable && bg) begin
      res.alpha = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_pix   <= pix_in;
      s1_store <= store_in;
    end
    if (adv) begin
      out_pix <= res;
    end
  end

  a_load_has_room: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("stage loaded while occupied and stalled");

  a_disabled_passes: assert property (@(posedge clk) disable iff (rst)
    (adv && !enable) |=> (out_pix == $past(s1_pix)))
    else $error("pixel altered while disabled");

  a_rgb_kept: assert property (@(posedge clk) disable iff (rst)
    adv |=> (out_pix.red == $past(s1_pix.red) && out_pix.green == $past(s1_pix.green)
             && out_pix.blue == $past(s1_pix.blue) && out_pix.last == $past(s1_pix.last)))
    else $error("color bytes changed in compare stage");

endmodule
`default_nettype wire

>>> src/depth_background_mask.sv
// Top level: depth background mask over an RGBA pixel stream.
//
//  Channel   Direction  Handshake                Contents
//  s_axis    in         tvalid/tready            tdata, tuser = command, tlast
//  m_axis    out        tvalid/tready            tdata, tlast
//  cfg       in         cfg_we                   cfg_index, cfg_data
//
// One transaction per cycle in both directions while m_axis does not stall;
// a pixel waits in the compare register for its registered reference RAM read.
// No clearing pass after reset: reference entries are defined once captured.
// A stall on m_axis fills the result and compare registers, then drops
// s_axis_tready; a capture command is a transaction of its own and gives no result.
`default_nettype none
module depth_background_mask
  import dbm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output      logic               s_axis_tready,
  input  wire logic [31:0]        s_axis_tdata,  // red, green, blue, alpha
  input  wire logic               s_axis_tuser,  // command
  input  wire logic               s_axis_tlast,
  output      logic               m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output      logic [31:0]        m_axis_tdata,  // red, green, blue, alpha
  output      logic               m_axis_tlast,
  input  wire logic               cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [ThreshW-1:0] cfg_data
);

  logic signed [ThreshW-1:0] threshold;
  logic                      compare_mode;
  logic                      enable;

  logic        acc;
  logic        pix_acc;
  logic        cmd_acc;
  pixel_t      pix_in;
  pixel_t      out_pix;
  frame_ctrl_t ctrl;
  logic [DepthW-1:0] ref_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      compare_mode <= MODE_NEARER;
      enable       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold    <= $signed(cfg_data);
        CFG_MODE:      compare_mode <= cfg_data[0];
        CFG_ENABLE:    enable       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign acc     = s_axis_tvalid & s_axis_tready;
  assign pix_acc = acc & (s_axis_tuser == CMD_PIXEL);
  assign cmd_acc = acc & (s_axis_tuser == CMD_CAPTURE);

  assign pix_in.red   = s_axis_tdata[7:0];
  assign pix_in.green = s_axis_tdata[15:8];
  assign pix_in.blue  = s_axis_tdata[23:16];
  assign pix_in.alpha = s_axis_tdata[31:24];
  assign pix_in.last  = s_axis_tlast;

  dbm_frame_ctrl u_frame (
    .clk     (clk),
    .rst     (rst),
    .pix_acc (pix_acc),
    .cmd_acc (cmd_acc),
    .last    (s_axis_tlast),
    .enable  (enable),
    .ctrl    (ctrl)
  );

  dbm_ram #(
    .WIDTH (DepthW),
    .DEPTH (MaxPixels)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ctrl.store),
    .waddr (ctrl.pos),
    .wdata ({pix_in.red, pix_in.green}),
    .re    (pix_acc),
    .raddr (ctrl.pos),
    .rdata (ref_rdata)
  );

  dbm_classify u_classify (
    .clk          (clk),
    .rst          (rst),
    .load         (pix_acc),
    .pix_in       (pix_in),
    .store_in     (ctrl.store),
    .ref_rdata    (ref_rdata),
    .threshold    (threshold),
    .compare_mode (compare_mode),
    .enable       (enable),
    .ready        (s_axis_tready),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_pix      (out_pix)
  );

  assign m_axis_tdata = {out_pix.alpha, out_pix.blue, out_pix.green, out_pix.red};
  assign m_axis_tlast = out_pix.last;

  a_cmd_no_result: assert property (@(posedge clk) disable iff (rst)
    (cmd_acc && !m_axis_tvalid && !$past(pix_acc)) |=> !m_axis_tvalid)
    else $error("capture command produced a result");

  a_store_on_pixel: assert property (@(posedge clk) disable iff (rst)
    ctrl.store |-> pix_acc)
    else $error("reference write without a pixel transaction");

endmodule
`default_nettype wire

>>> bench/depth_background_mask_test.sv
// Self-checking testbench for depth_background_mask: directed and random RGBA frames checked against a predictor.
`timescale 1ns / 1ps
module depth_background_mask_test;
  import dbm_pkg::*;

  class mask_tracker;
    bit [15:0]      ref_depth[];
    int             ref_extent = 0;
    bit [AddrW-1:0] pos = '0;
    bit             pending = 1'b1;
    bit             capturing = 1'b0;
    bit             at_start = 1'b1;
    int             thr = 100;
    bit             mode = MODE_NEARER;
    bit             en = 1'b1;
    pixel_t         masked_pixels[$];
    int             errors = 0;
    int             checked = 0;
    int             captures = 0;
    int             frames = 0;

    function new();
      ref_depth = new[MaxPixels];
    endfunction

    function void write_cfg(logic [CfgIdxW-1:0] idx, logic [ThreshW-1:0] data);
      case (idx)
        CFG_THRESHOLD: thr = $signed(data);
        CFG_MODE:      mode = data[0];
        CFG_ENABLE:    en = data[0];
        default: ;
      endcase
    endfunction

    function void take_pixel(bit cmd, pixel_t px);
      int     depth;
      int     refd;
      int     diff;
      int     mag;
      bit     bg;
      pixel_t res;
      if (cmd == CMD_CAPTURE) begin
        pending = 1'b1;
        captures++;
        return;
      end
      if (at_start) begin
        capturing = en ? pending : 1'b0;
        if (en) pending = 1'b0;
        at_start = 1'b0;
        frames++;
      end
      res = px;
      if (en) begin
        depth = {px.red, px.green};
        if (capturing) begin
          ref_depth[pos] = depth[15:0];
          if (int'(pos) + 1 > ref_extent) ref_extent = int'(pos) + 1;
        end
        refd = ref_depth[pos];
        diff = depth - refd;
        diff = diff < 0 ? -diff : diff;
        mag = thr < 0 ? -thr : thr;
        bg = (mode == MODE_NEARER) ? (depth > refd - thr) : (diff < mag);
        if (px.alpha != 8'd0 && bg) res.alpha = 8'd0;
      end
      masked_pixels = {masked_pixels, res};
      if (px.last) begin
        pos = '0;
        at_start = 1'b1;
      end else begin
        pos = pos + 1'b1;
      end
    endfunction

    task report(string what, int want, int got);
      if (errors < 50) $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
      errors++;
    endtask

    task match_output(pixel_t got);
      pixel_t want;
      if (masked_pixels.size() == 0) begin
        report("pixel with none outstanding", 0, int'(got[32:1]));
        return;
      end
      want = masked_pixels.pop_front();
      checked++;
      if (got.red !== want.red) report("red", int'(want.red), int'(got.red));
      if (got.green !== want.green) report("green", int'(want.green), int'(got.green));
      if (got.blue !== want.blue) report("blue", int'(want.blue), int'(got.blue));
      if (got.alpha !== want.alpha) report("alpha", int'(want.alpha), int'(got.alpha));
      if (got.last !== want.last) report("last", int'(want.last), int'(got.last));
    endtask

    task close_out();
      if (masked_pixels.size() != 0) report("pixels never delivered", 0, masked_pixels.size());
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;  // red, green, blue, alpha
  logic               s_axis_tuser = 1'b0;  // command
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;  // red, green, blue, alpha
  logic               m_axis_tlast;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CFG_THRESHOLD;
  logic [ThreshW-1:0] cfg_data = '0;

  bit                 src_idle_on = 1'b1;
  bit                 snk_idle_on = 1'b1;
  int                 items_sent = 0;
  mask_tracker        masks;

  depth_background_mask u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic pixel_t pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a, logic l);
    return {r, g, b, a, l};
  endfunction

  function automatic pixel_t random_pixel(bit l);
    return pack_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255),
                      $urandom_range(255), l);
  endfunction

  always @(posedge clk) begin
    m_axis_tready <= snk_idle_on ? ($urandom_range(99) >= 33) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      masks.match_output(pack_pixel(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
                                    m_axis_tdata[31:24], m_axis_tlast));
  end

  task send_item(bit cmd, pixel_t px);
    while (src_idle_on && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {px.alpha, px.blue, px.green, px.red};
    s_axis_tlast <= px.last;
    do @(posedge clk); while (!s_axis_tready);
    masks.take_pixel(cmd, px);
    items_sent++;
  endtask

  task request_capture();
    send_item(CMD_CAPTURE, random_pixel($urandom_range(1)));
  endtask

  // hold off the stream until every pixel has come back
  task drain();
    s_axis_tvalid <= 1'b0;
    while (masks.masked_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [CfgIdxW-1:0] idx, logic [ThreshW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    masks.write_cfg(idx, val);
    @(posedge clk);
  endtask

  task configure(int thr, bit mode, bit en);
    drain();
    write_reg(CFG_THRESHOLD, thr[ThreshW-1:0]);
    write_reg(CFG_MODE, {{(ThreshW-1){1'b0}}, mode});
    write_reg(CFG_ENABLE, {{(ThreshW-1){1'b0}}, en});
  endtask

  // steer depth near the stored reference so both sides of the compare get hit
  task send_frame(int len);
    pixel_t    px;
    int        span;
    int        off;
    bit [15:0] d;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(49) == 0) request_capture();
      px = random_pixel(i == len - 1);
      if ($urandom_range(7) == 0) px.alpha = 8'd0;
      if (masks.en && i < masks.ref_extent && $urandom_range(2) != 0) begin
        span = (masks.thr < 0 ? -masks.thr : masks.thr) + 2;
        off = $urandom_range(2 * span) - span;
        d = 16'(int'(masks.ref_depth[i]) + off);
        px.red = d[15:8];
        px.green = d[7:0];
      end
      send_item(CMD_PIXEL, px);
    end
  endtask

  // keep reads inside the part of the reference that has been captured
  task random_frame();
    int len;
    bit reads;
    if ($urandom_range(3) == 0 || (masks.en && masks.ref_extent == 0)) request_capture();
    reads = masks.en && !masks.pending;
    len = ($urandom_range(9) == 0) ? $urandom_range(300, 41) : $urandom_range(40, 1);
    if (reads && len > masks.ref_extent) len = $urandom_range(masks.ref_extent, 1);
    send_frame(len);
  endtask

  initial begin
    int thr;
    bit mode;
    bit en;
    int k;
    masks = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // first frame captures out of reset
    send_item(CMD_PIXEL, pack_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'h12, 8'h34, 8'h80, 8'h00, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'h80, 8'h00, 8'h7F, 8'h80, 1'b1));
    // nearer-than test at and around ref - threshold, capture request mid-frame
    send_item(CMD_PIXEL, pack_pixel(8'h00, 8'h00, 8'h55, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'hFF, 8'h9B, 8'hAA, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'h11, 8'hD1, 8'h01, 8'hFE, 1'b0));
    request_capture();
    send_item(CMD_PIXEL, pack_pixel(8'h00, 8'h00, 8'hFE, 8'h7F, 1'b1));
    send_item(CMD_PIXEL, pack_pixel(8'h01, 8'h00, 8'h33, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'hFF, 8'hFE, 8'h44, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'h00, 8'h02, 8'h66, 8'hFF, 1'b1));
    // within test with a negative threshold, both sides of the boundary
    configure(-3, MODE_WITHIN, 1'b1);
    send_item(CMD_PIXEL, pack_pixel(8'h01, 8'h02, 8'h10, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'hFF, 8'hFB, 8'h20, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'h00, 8'h00, 8'h30, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'h80, 8'h03, 8'h40, 8'hFF, 1'b1));
    // disabled: pass through, capture request stays pending
    configure(100, MODE_NEARER, 1'b0);
    request_capture();
    send_item(CMD_PIXEL, pack_pixel(8'hAB, 8'hCD, 8'hEF, 8'hFF, 1'b0));
    send_item(CMD_PIXEL, pack_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1));
    configure(100, MODE_NEARER, 1'b1);
    send_item(CMD_PIXEL, pack_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));

    k = 0;
    while (items_sent < 1850) begin
      case (k)
        0: begin thr = 65535; mode = MODE_NEARER; en = 1'b1; end
        1: begin thr = -65535; mode = MODE_WITHIN; en = 1'b1; end
        2: begin thr = 0; mode = MODE_WITHIN; en = 1'b1; end
        3: begin thr = 0; mode = MODE_NEARER; en = 1'b0; end
        default: begin
          thr = $urandom_range(1) ? $urandom_range(600) - 300 : $urandom_range(131070) - 65535;
          mode = $urandom_range(1);
          en = $urandom_range(4) != 0;
        end
      endcase
      configure(thr, mode, en);
      src_idle_on <= (k % 5 != 2);
      snk_idle_on <= (k % 5 != 2);
      for (int j = $urandom_range(8, 3); j > 0 && items_sent < 1850; j--) begin
        if (j == 2 && k % 3 == 0) drain();
        random_frame();
      end
      k++;
    end

    s_axis_tvalid <= 1'b0;
    for (int w = 0; w < 20000 && masks.masked_pixels.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    masks.close_out();
    $display("%0d transactions taken (%0d capture commands) over %0d frames, %0d pixels checked",
             items_sent, masks.captures, masks.frames, masks.checked);
    $display("thresholds at both extremes and zero, both compare modes, enable off and on, "
             , "capture requests mid-frame and while disabled");
    if (masks.errors == 0) begin
      $display("depth_background_mask verification clean");
    end else begin
      $display("depth_background_mask verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("depth_background_mask verification failed");
    $finish;
  end

endmodule

>>> filelist.f
src/dbm_pkg.sv
src/dbm_ram.sv
src/dbm_frame_ctrl.sv
src/dbm_classify.sv
src/depth_background_mask.sv
bench/depth_background_mask_test.sv
